[design/idc_pkg.sv]
// shared types and constants of the imu dead-zone calibrator
package idc_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 17;
    localparam int SUM_W      = 33;
    localparam int SQ_W       = 47;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MARGIN   = 2'd3;

    localparam logic [15:0] RST_SAMPLE_COUNT  = 16'd100;
    localparam logic [23:0] RST_VARIANCE_GAIN = 24'd262144;
    localparam logic [THR_W-1:0] THR_MAX      = 17'h1FFFF;
    localparam logic [AXIS_W-1:0] LAST_AXIS   = 2'(NUM_AXES - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_NLO, ST_NHI, ST_NN, ST_SUB, ST_DIV,
        ST_GAIN, ST_PEAK, ST_STORE, ST_CLEAR
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_SQ, OP_NLO, OP_NHI, OP_NN, OP_SUB, OP_DIV,
        OP_GAIN, OP_PEAK, OP_STORE, OP_CLEAR
    } t_op;

    typedef struct packed {
        logic              idle;
        t_op               op;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic finish;
        logic peak_mode;
    } t_sts;

endpackage

[design/idc_ctrl.sv]
// sequencer for the threshold update after a calibration run
module idc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  idc_pkg::t_sts i_sts,
    output idc_pkg::t_cmd o_cmd
);

    idc_pkg::t_state r_state, n_state;
    logic [idc_pkg::AXIS_W-1:0]    r_axis, n_axis;
    logic [idc_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= idc_pkg::ST_IDLE;
            r_axis    <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_div_cnt = r_div_cnt;
        o_cmd.idle = 1'b0;
        o_cmd.op   = idc_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        unique case (r_state)
            idc_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                n_axis     = '0;
                if (i_sts.finish) begin
                    n_state = i_sts.peak_mode ? idc_pkg::ST_PEAK : idc_pkg::ST_SQ;
                end
            end
            idc_pkg::ST_SQ: begin
                o_cmd.op = idc_pkg::OP_SQ;
                n_state  = idc_pkg::ST_NLO;
            end
            idc_pkg::ST_NLO: begin
                o_cmd.op = idc_pkg::OP_NLO;
                n_state  = idc_pkg::ST_NHI;
            end
            idc_pkg::ST_NHI: begin
                o_cmd.op = idc_pkg::OP_NHI;
                n_state  = idc_pkg::ST_NN;
            end
            idc_pkg::ST_NN: begin
                o_cmd.op = idc_pkg::OP_NN;
                n_state  = idc_pkg::ST_SUB;
            end
            idc_pkg::ST_SUB: begin
                o_cmd.op  = idc_pkg::OP_SUB;
                n_div_cnt = '0;
                n_state   = idc_pkg::ST_DIV;
            end
            idc_pkg::ST_DIV: begin
                o_cmd.op  = idc_pkg::OP_DIV;
                n_div_cnt = r_div_cnt + 1'b1;
                if (&r_div_cnt) begin
                    n_state = idc_pkg::ST_GAIN;
                end
            end
            idc_pkg::ST_GAIN: begin
                o_cmd.op = idc_pkg::OP_GAIN;
                n_state  = idc_pkg::ST_STORE;
            end
            idc_pkg::ST_PEAK: begin
                o_cmd.op = idc_pkg::OP_PEAK;
                n_state  = idc_pkg::ST_STORE;
            end
            idc_pkg::ST_STORE: begin
                o_cmd.op = idc_pkg::OP_STORE;
                if (r_axis == idc_pkg::LAST_AXIS) begin
                    n_state = idc_pkg::ST_CLEAR;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = i_sts.peak_mode ? idc_pkg::ST_PEAK : idc_pkg::ST_SQ;
                end
            end
            idc_pkg::ST_CLEAR: begin
                o_cmd.op = idc_pkg::OP_CLEAR;
                n_state  = idc_pkg::ST_IDLE;
            end
            default: begin
                n_state = idc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/idc_dp.sv]
// datapath: config registers, dead-zone filter, accumulators and threshold math
module idc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [idc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [idc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_accept,
    input  logic                            i_kind,
    input  logic signed [15:0]              i_sample [idc_pkg::NUM_AXES],
    input  idc_pkg::t_cmd                   i_cmd,
    output idc_pkg::t_sts                   o_sts,
    output logic signed [15:0]              o_out [idc_pkg::NUM_AXES]
);

    logic [15:0] r_sample_count;
    logic        r_peak_mode;
    logic [23:0] r_variance_gain;
    logic [15:0] r_peak_margin;

    logic [15:0]                    r_cnt;
    logic signed [idc_pkg::SUM_W-1:0] r_sum  [idc_pkg::NUM_AXES];
    logic [idc_pkg::SQ_W-1:0]       r_sumsq [idc_pkg::NUM_AXES];
    logic [15:0]                    r_peak [idc_pkg::NUM_AXES];
    logic [idc_pkg::THR_W-1:0]      r_thr  [idc_pkg::NUM_AXES];

    logic [63:0] r_prod, r_sq, r_num, r_dvd;
    logic [31:0] r_den, r_rem;
    logic        r_qhi;

    logic [15:0] cnt_inc;
    logic [15:0] mag_in [idc_pkg::NUM_AXES];
    logic [15:0] mag_out [idc_pkg::NUM_AXES];
    logic [31:0] sum_abs;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [idc_pkg::THR_W-1:0] thr_new;

    // filter with the current thresholds
    always_comb begin
        for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
            mag_in[a]  = i_sample[a][15] ? 16'(-i_sample[a]) : 16'(i_sample[a]);
            o_out[a]   = ({1'b0, mag_in[a]} < r_thr[a]) ? 16'sd0 : i_sample[a];
            mag_out[a] = o_out[a][15] ? 16'(-o_out[a]) : 16'(o_out[a]);
        end
    end

    assign cnt_inc = r_cnt + 1'b1;
    assign o_sts.finish = i_accept && i_kind && (cnt_inc >= r_sample_count)
                          && (cnt_inc != 16'd0);
    assign o_sts.peak_mode = r_peak_mode;

    assign sum_abs = r_sum[i_cmd.axis][idc_pkg::SUM_W-1]
                   ? 32'(-r_sum[i_cmd.axis]) : 32'(r_sum[i_cmd.axis]);

    // shared 32x32 multiplier, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            idc_pkg::OP_SQ: begin
                mul_a = sum_abs;
                mul_b = sum_abs;
            end
            idc_pkg::OP_NLO: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {8'd0, r_sumsq[i_cmd.axis][23:0]};
            end
            idc_pkg::OP_NHI: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {9'd0, r_sumsq[i_cmd.axis][46:24]};
            end
            idc_pkg::OP_NN: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {16'd0, r_cnt};
            end
            idc_pkg::OP_GAIN: begin
                mul_a = r_dvd[31:0];
                mul_b = {8'd0, r_variance_gain};
            end
            idc_pkg::OP_PEAK: begin
                mul_a = {16'd0, r_peak[i_cmd.axis]};
                mul_b = {15'd0, 17'(17'h10000 + {1'b0, r_peak_margin})};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[63]};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    assign thr_new = ((r_qhi && (r_variance_gain != 24'd0)) || (|r_prod[63:33]))
                   ? idc_pkg::THR_MAX : r_prod[32:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= idc_pkg::RST_SAMPLE_COUNT;
            r_peak_mode     <= 1'b0;
            r_variance_gain <= idc_pkg::RST_VARIANCE_GAIN;
            r_peak_margin   <= '0;
            r_cnt           <= '0;
            for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                r_sum[a]   <= '0;
                r_sumsq[a] <= '0;
                r_peak[a]  <= '0;
                r_thr[a]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    idc_pkg::REG_SAMPLE_COUNT:  r_sample_count  <= i_cfg_wdata[15:0];
                    idc_pkg::REG_PEAK_MODE:     r_peak_mode     <= i_cfg_wdata[0];
                    idc_pkg::REG_VARIANCE_GAIN: r_variance_gain <= i_cfg_wdata;
                    idc_pkg::REG_PEAK_MARGIN:   r_peak_margin   <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_accept && i_kind) begin
                r_cnt <= cnt_inc;
                for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                    r_sum[a]   <= r_sum[a] + idc_pkg::SUM_W'(o_out[a]);
                    r_sumsq[a] <= r_sumsq[a]
                                + idc_pkg::SQ_W'({16'd0, mag_out[a]} * {16'd0, mag_out[a]});
                    if (mag_out[a] > r_peak[a]) begin
                        r_peak[a] <= mag_out[a];
                    end
                end
            end
            if (i_cmd.op == idc_pkg::OP_STORE) begin
                r_thr[i_cmd.axis] <= thr_new;
            end
            if (i_cmd.op == idc_pkg::OP_CLEAR) begin
                r_cnt <= '0;
                for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                    r_sum[a]   <= '0;
                    r_sumsq[a] <= '0;
                    r_peak[a]  <= '0;
                end
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            idc_pkg::OP_SQ: begin
                r_prod <= mul_p;
            end
            idc_pkg::OP_NLO: begin
                r_sq   <= r_prod;
                r_prod <= mul_p;
            end
            idc_pkg::OP_NHI: begin
                r_num  <= r_prod;
                r_prod <= mul_p;
            end
            idc_pkg::OP_NN: begin
                r_num  <= r_num + {r_prod[39:0], 24'd0};
                r_prod <= mul_p;
            end
            idc_pkg::OP_SUB: begin
                r_den <= r_prod[31:0];
                r_rem <= '0;
                r_dvd <= (r_num >= r_sq) ? (r_num - r_sq) : 64'd0;
            end
            idc_pkg::OP_DIV: begin
                r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                r_dvd <= {r_dvd[62:0], rem_ge};
            end
            idc_pkg::OP_GAIN: begin
                r_qhi  <= |r_dvd[63:32];
                r_prod <= mul_p;
            end
            idc_pkg::OP_PEAK: begin
                r_qhi  <= 1'b0;
                r_prod <= mul_p;
            end
            default: ;
        endcase
    end

endmodule

[design/imu_deadzone_calibrator.sv]
// top level of the imu dead-zone calibrator with stream ports and result register
//
// three-axis dead-zone filter for one imu. every input word yields one output word:
// an axis whose magnitude is below its threshold comes out as zero. calibration words
// (tuser = 1) are also summed per axis (sum, sum of squares, peak magnitude). the word
// that completes sample_count of them carries calibration_done and is itself filtered
// with the old thresholds; after it, a sequencer recomputes the three thresholds one
// axis at a time through a shared 32x32 multiplier and a one-bit-per-cycle divider.
// a normal or non-finishing word leaves the input open unless the output stalls; the
// finishing word keeps it closed while each axis passes square, products, subtract,
// divide, gain and store (peak and store in peak mode), then a clear. configuration
// writes take effect at once and are meant for idle periods only.
module imu_deadzone_calibrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  logic [0:0]  i_s_tuser,   // kind [0]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // out_x [15:0], out_y [31:16], out_z [47:32]
    output logic [0:0]  o_m_tuser    // calibration_done [0]
);

    idc_pkg::t_cmd w_cmd;
    idc_pkg::t_sts w_sts;

    logic signed [15:0] w_sample [idc_pkg::NUM_AXES];
    logic signed [15:0] w_out    [idc_pkg::NUM_AXES];
    logic               s_acc;

    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic        r_m_done;

    assign w_sample[0] = i_s_tdata[15:0];
    assign w_sample[1] = i_s_tdata[31:16];
    assign w_sample[2] = i_s_tdata[47:32];

    // take a word only while the sequencer is idle and the result slot can be refilled
    assign o_s_tready = w_cmd.idle && (!r_m_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    idc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    idc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (s_acc),
        .i_kind      (i_s_tuser[0]),
        .i_sample    (w_sample),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (w_out)
    );

    // output register, valid is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_acc) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_m_data <= {w_out[2], w_out[1], w_out[0]};
            r_m_done <= w_sts.finish;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_done;

`ifndef SYNTHESIS
    // a finishing word closes the input while thresholds are recomputed
    a_finish_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && w_sts.finish) |=> !o_s_tready)
        else $error("input open right after a finishing word");

    // every accepted word leaves a result in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (o_m_tvalid && (o_m_tuser[0] == $past(w_sts.finish))))
        else $error("accepted word without result");

    // the sequencer never runs while a word is taken
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op != idc_pkg::OP_NONE) |-> !s_acc)
        else $error("word accepted during threshold update");
`endif

endmodule

[tb/sv/imu_deadzone_calibrator_chk.sv]
`timescale 1ns / 100ps
// checker of the imu dead-zone calibrator: watches both streams, predicts and compares
module imu_deadzone_calibrator_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        done;
        logic [47:0] axes;
    } t_filtered;

    t_filtered filtered_q[$];

    logic [15:0] cnt_limit;
    logic        use_peak;
    logic [23:0] gain;
    logic [15:0] margin;
    logic [15:0] run_len;
    logic signed [32:0] sum_acc [idc_pkg::NUM_AXES];
    logic [46:0] sq_acc [idc_pkg::NUM_AXES];
    logic [15:0] peak_acc [idc_pkg::NUM_AXES];
    logic [16:0] thr [idc_pkg::NUM_AXES];

    assign o_pending = filtered_q.size();

    function automatic logic [16:0] clamp_thr(logic [127:0] v);
        return (v > 128'(idc_pkg::THR_MAX)) ? idc_pkg::THR_MAX : v[16:0];
    endfunction

    task automatic predict_word(logic kind, logic [47:0] din);
        logic signed [15:0] s;
        logic [16:0] m;
        logic [47:0] res;
        logic [127:0] nsq, sq, v, n;
        logic [32:0] asum;
        t_filtered f;
        for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
            s = din[a*16 +: 16];
            m = s < 0 ? 17'(-32'(s)) : 17'(s);
            res[a*16 +: 16] = (m < thr[a]) ? 16'd0 : s;
        end
        f.done = 1'b0;
        if (kind) begin
            for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                s = res[a*16 +: 16];
                m = s < 0 ? 17'(-32'(s)) : 17'(s);
                sum_acc[a] = sum_acc[a] + 33'(s);
                sq_acc[a] = sq_acc[a] + 47'(m) * 47'(m);
                if (m > 17'(peak_acc[a])) peak_acc[a] = m[15:0];
            end
            run_len = run_len + 16'd1;
            if (run_len >= cnt_limit && run_len != 0) begin
                n = 128'(run_len);
                for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                    if (use_peak) begin
                        thr[a] = clamp_thr((128'(peak_acc[a]) * (128'd65536 + margin)) >> 16);
                    end else begin
                        asum = sum_acc[a] < 0 ? -sum_acc[a] : sum_acc[a];
                        nsq = n * 128'(sq_acc[a]);
                        sq = 128'(asum) * 128'(asum);
                        v = nsq >= sq ? (nsq - sq) / (n * n) : 128'd0;
                        thr[a] = clamp_thr((v * 128'(gain)) >> 16);
                    end
                    sum_acc[a] = '0;
                    sq_acc[a] = '0;
                    peak_acc[a] = '0;
                end
                run_len = '0;
                f.done = 1'b1;
            end
        end
        f.axes = res;
        filtered_q.push_back(f);
    endtask

    always @(posedge i_clk) begin
        t_filtered exp_w;
        if (!i_rst_n) begin
            cnt_limit = idc_pkg::RST_SAMPLE_COUNT;
            use_peak = 1'b0;
            gain = idc_pkg::RST_VARIANCE_GAIN;
            margin = '0;
            run_len = '0;
            for (int a = 0; a < idc_pkg::NUM_AXES; a++) begin
                sum_acc[a] = '0;
                sq_acc[a] = '0;
                peak_acc[a] = '0;
                thr[a] = '0;
            end
            filtered_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    idc_pkg::REG_SAMPLE_COUNT:  cnt_limit = i_cfg_wdata[15:0];
                    idc_pkg::REG_PEAK_MODE:     use_peak = i_cfg_wdata[0];
                    idc_pkg::REG_VARIANCE_GAIN: gain = i_cfg_wdata;
                    idc_pkg::REG_PEAK_MARGIN:   margin = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // output first: a word accepted now cannot come out in the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (filtered_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected output word %h done %b", i_m_tdata, i_m_tuser);
                end else begin
                    exp_w = filtered_q.pop_front();
                    if (exp_w.axes !== i_m_tdata || exp_w.done !== i_m_tuser[0]) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %h done %b, got %h done %b",
                                     exp_w.axes, exp_w.done, i_m_tdata, i_m_tuser);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tuser[0], i_s_tdata);
        end
    end

endmodule

[tb/sv/imu_deadzone_calibrator_tb.sv]
`timescale 1ns / 100ps
// testbench top of the imu dead-zone calibrator: stimulus, reset and verdict
module imu_deadzone_calibrator_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    logic [0:0]  i_s_tuser;   // kind [0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // out_x [15:0], out_y [31:16], out_z [47:32]
    logic [0:0]  o_m_tuser;   // calibration_done [0]

    int fail_count;
    int pending;
    int cycles;
    bit rx_idle_off;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 250;   // covers the busy time after a finishing word in variance mode

    imu_deadzone_calibrator uut (.*);

    imu_deadzone_calibrator_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("imu_deadzone_calibrator regression: fail");
            $finish;
        end
    end

    // receiver: random stall per word, sometimes none at all
    initial begin
        int gap;
        i_m_tready = 1'b0;
        forever begin
            gap = rx_idle_off ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    int tx_gap_max;

    // one word onto the input stream, valid held until accepted
    task automatic send_word(logic kind, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_s_tvalid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // wait until every output word is back and the sequencer has settled
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis(int spread);
        int r;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom));
            default: begin
                r = $urandom_range(0, 2 * spread);
                return 16'(r - spread);
            end
        endcase
    endfunction

    task automatic random_words(int count, int spread, int cal_pct);
        for (int k = 0; k < count; k++)
            send_word($urandom_range(0, 99) < cal_pct, rand_axis(spread),
                      rand_axis(spread), rand_axis(spread));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        cycles = 0;
        rx_idle_off = 1'b0;
        tx_gap_max = 12;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes with no dead zone, then tiny runs
        send_word(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
        send_word(1'b0, 16'hFFFF, 16'h0001, 16'h8000);
        settle();
        write_reg(idc_pkg::REG_SAMPLE_COUNT, 24'd2);
        write_reg(idc_pkg::REG_PEAK_MODE, 24'd1);
        write_reg(idc_pkg::REG_PEAK_MARGIN, 24'hFFFF);
        send_word(1'b1, 16'h8000, 16'h0010, 16'hFFF0);   // most negative sample as peak
        send_word(1'b1, 16'h0005, 16'h7FFF, 16'h0003);   // finishes, old thresholds
        send_word(1'b0, 16'h8000, 16'h7FFF, 16'h0020);   // new thresholds zero the extremes
        send_word(1'b0, 16'hFFFF, 16'h0001, 16'h0000);
        settle();
        write_reg(idc_pkg::REG_PEAK_MODE, 24'd0);
        write_reg(idc_pkg::REG_VARIANCE_GAIN, 24'hFFFFFF);
        write_reg(idc_pkg::REG_SAMPLE_COUNT, 24'd0);     // zero count: one-word run
        write_reg(idc_pkg::REG_PEAK_MARGIN, 24'd0);
        send_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
        settle();
        write_reg(idc_pkg::REG_SAMPLE_COUNT, 24'd3);
        send_word(1'b1, 16'h7FFF, 16'h8000, 16'h0001);
        send_word(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_word(1'b1, 16'h1234, 16'h0000, 16'h0004);
        settle();
        // lowering the count mid-run finishes on the next calibration word
        write_reg(idc_pkg::REG_VARIANCE_GAIN, 24'd0);
        write_reg(idc_pkg::REG_SAMPLE_COUNT, 24'd5);
        send_word(1'b1, 16'h0100, 16'h0200, 16'h0300);
        send_word(1'b1, 16'hFF00, 16'hFE00, 16'hFD00);
        settle();
        write_reg(idc_pkg::REG_SAMPLE_COUNT, 24'd1);
        send_word(1'b1, 16'h0001, 16'h0002, 16'h0003);
        send_word(1'b0, 16'h0001, 16'h8000, 16'h7FFF);
        settle();
        write_reg(idc_pkg::REG_PEAK_MARGIN, 24'd0);      // clear margin

        // random phases over a range of settings, extremes among them
        for (int ph = 0; ph < 18; ph++) begin
            logic [23:0] cnt;
            int spread;
            case (ph % 6)
                0: cnt = 24'd1;
                1: cnt = 24'($urandom_range(2, 8));
                2: cnt = 24'($urandom_range(9, 40));
                3: cnt = 24'd0;
                4: cnt = 24'($urandom_range(2, 20));
                default: cnt = 24'(ph == 17 ? 65535 : $urandom_range(3, 12));
            endcase
            write_reg(idc_pkg::REG_SAMPLE_COUNT, cnt);
            write_reg(idc_pkg::REG_PEAK_MODE, 24'(ph % 2));
            case (ph % 4)
                0: write_reg(idc_pkg::REG_VARIANCE_GAIN, idc_pkg::RST_VARIANCE_GAIN);
                1: write_reg(idc_pkg::REG_VARIANCE_GAIN, 24'hFFFFFF);
                2: write_reg(idc_pkg::REG_VARIANCE_GAIN, 24'd0);
                default: write_reg(idc_pkg::REG_VARIANCE_GAIN,
                                   24'($urandom_range(0, 24'hFFFFFF)));
            endcase
            write_reg(idc_pkg::REG_PEAK_MARGIN,
                      (ph % 3 == 0) ? 24'hFFFF : 24'($urandom_range(0, 65535)));
            spread = (ph % 3 == 0) ? 32767 : (ph % 3 == 1 ? 64 : 2000);
            rx_idle_off = (ph % 5 == 4);
            tx_gap_max = (ph % 5 == 3) ? 0 : 12;
            random_words(100, spread, (ph % 6 == 5) ? 40 : 80);
            settle();
        end

        if (fail_count == 0)
            $display("imu_deadzone_calibrator regression: pass");
        else
            $display("imu_deadzone_calibrator regression: fail");
        $finish;
    end

endmodule

[imu_deadzone_calibrator.f]
design/idc_pkg.sv
design/idc_ctrl.sv
design/idc_dp.sv
design/imu_deadzone_calibrator.sv
tb/sv/imu_deadzone_calibrator_chk.sv
tb/sv/imu_deadzone_calibrator_tb.sv
